// File: sv/etd_pkg.sv
// shared types and constants of the enigma tilemap decompressor
// no dependencies; used by front, queue, back and top level
package etd_pkg;

  // how a run moves from one word to the next
  typedef enum logic [1:0] {
    STEP_HOLD,
    STEP_UP,
    STEP_DOWN
  } run_step_e;

  // one run handed from the command decoder to the word expander
  typedef struct packed {
    logic [15:0] word;
    logic [3:0]  count;
    run_step_e   step;
    logic        stream_end;
    logic        last;
  } run_t;

  // header phase once all six header bytes are in
  localparam logic [2:0] PHASE_STREAM = 3'd6;

  // command lengths in bits
  localparam logic [2:0] CMD_SHORT_BITS = 3'd6;
  localparam logic [2:0] CMD_LONG_BITS  = 3'd7;

  // long command modes
  localparam logic [2:0] MODE_REPEAT = 3'd4;
  localparam logic [2:0] MODE_INC    = 3'd5;
  localparam logic [2:0] MODE_DEC    = 3'd6;
  localparam logic [2:0] MODE_INLINE = 3'd7;

  // count field that turns an inline command into end of stream
  localparam logic [3:0] COUNT_END = 4'hF;

  // words per byte and room needed before a new command starts
  localparam logic [5:0] MAX_RESULTS = 6'd33;
  localparam logic [5:0] CMD_ROOM    = 6'd16;

  // largest tile bit count
  localparam logic [4:0] TILE_BITS_MAX = 5'd16;

endpackage

// File: sv/etd_front.sv
// front end: header parsing, bit reader and command decoding into runs
// depends on etd_pkg; feeds the run queue
module etd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     tile_base_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      data_byte_i,
  output logic            push_o,
  output etd_pkg::run_t   push_data_o,
  input  logic            full_i
);

  typedef enum logic {
    F_IDLE,
    F_STEP
  } front_state_e;

  // header byte positions
  localparam logic [2:0] PH_TILE_BITS = 3'd0;
  localparam logic [2:0] PH_FLAGS     = 3'd1;
  localparam logic [2:0] PH_INC_LO    = 3'd3;
  localparam logic [2:0] PH_STATIC_LO = 3'd5;

  front_state_e  state_q, state_d;
  logic [2:0]    hdr_phase_q, hdr_phase_d;
  logic [4:0]    tile_bits_q, tile_bits_d;
  logic          vflip_q, vflip_d;
  logic          hflip_q, hflip_d;
  logic [7:0]    hi_byte_q, hi_byte_d;
  logic [15:0]   up_tile_q, up_tile_d;
  logic [15:0]   static_tile_q, static_tile_d;
  logic [31:0]   acc_q, acc_d;
  logic [5:0]    held_q, held_d;
  logic [4:0]    pend_q, pend_d;
  logic [5:0]    n_q, n_d;
  logic          hold_valid_q, hold_valid_d;
  etd_pkg::run_t hold_q, hold_d;

  logic [4:0]    need;
  logic [5:0]    need_cmd;
  logic [31:0]   aligned;
  logic [2:0]    pre;
  logic [31:0]   after_p, after_v, after_h, tile_val;
  logic          vbit, hbit;
  logic [15:0]   tile;
  logic [7:0]    neg_byte, mag;
  logic [15:0]   hdr_word;
  logic [2:0]    mode;
  logic [3:0]    cnt6, cnt7;
  logic          brk, run_new;
  etd_pkg::run_t run;

  // bits a decoded tile takes
  assign need     = 5'(tile_bits_q + 5'(vflip_q) + 5'(hflip_q));
  assign need_cmd = 6'(need) + 6'(etd_pkg::CMD_LONG_BITS);

  // held bits left-aligned: bit 31 is the next stream bit
  assign aligned = acc_q << (6'd32 - held_q);
  assign mode    = aligned[31:29];
  assign cnt6    = aligned[29:26];
  assign cnt7    = aligned[28:25];

  // tile decode after the command prefix, if any
  assign pre      = (pend_q != 5'd0) ? 3'd0 : etd_pkg::CMD_LONG_BITS;
  assign after_p  = aligned << pre;
  assign vbit     = vflip_q & after_p[31];
  assign after_v  = after_p << vflip_q;
  assign hbit     = hflip_q & after_v[31];
  assign after_h  = after_v << hflip_q;
  assign tile_val = after_h >> (6'd32 - {1'b0, tile_bits_q});
  assign tile     = {tile_base_i[15:13], tile_base_i[12] | vbit, tile_base_i[11] | hbit,
                     tile_base_i[10:0]} + tile_val[15:0];

  // header helpers
  assign neg_byte = 8'(~data_byte_i + 8'd1);
  assign mag      = data_byte_i[7] ? neg_byte : data_byte_i;
  assign hdr_word = {hi_byte_q, data_byte_i} + tile_base_i;

  assign in_ready_o = (state_q == F_IDLE);

  // header parsing and command step: one loop pass per cycle unless a held run waits on a full queue
  always_comb begin
    brk      = 1'b0;
    run_new  = 1'b0;
    run      = '0;
    run.step = etd_pkg::STEP_HOLD;
    state_d       = state_q;
    hdr_phase_d   = hdr_phase_q;
    tile_bits_d   = tile_bits_q;
    vflip_d       = vflip_q;
    hflip_d       = hflip_q;
    hi_byte_d     = hi_byte_q;
    up_tile_d     = up_tile_q;
    static_tile_d = static_tile_q;
    acc_d         = acc_q;
    held_d        = held_q;
    pend_d        = pend_q;
    n_d           = n_q;
    hold_valid_d  = hold_valid_q;
    hold_d        = hold_q;
    push_o        = 1'b0;
    push_data_o   = hold_q;

    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          if (hdr_phase_q != etd_pkg::PHASE_STREAM) begin
            hdr_phase_d = hdr_phase_q + 3'd1;
            case (hdr_phase_q)
              PH_TILE_BITS: begin
                if (data_byte_i == 8'h80 || mag > 8'(etd_pkg::TILE_BITS_MAX)) begin
                  tile_bits_d = etd_pkg::TILE_BITS_MAX;
                end else begin
                  tile_bits_d = mag[4:0];
                end
              end
              PH_FLAGS: begin
                vflip_d = data_byte_i[0];
                hflip_d = data_byte_i[1];
              end
              PH_INC_LO:    up_tile_d     = hdr_word;
              PH_STATIC_LO: static_tile_d = hdr_word;
              default:      hi_byte_d     = data_byte_i;
            endcase
          end else begin
            acc_d   = {acc_q[23:0], data_byte_i};
            held_d  = held_q + 6'd8;
            n_d     = '0;
            state_d = F_STEP;
          end
        end
      end
      F_STEP: begin
        if (!(hold_valid_q && full_i)) begin
          if (pend_q != 5'd0) begin
            // inline tile
            if (held_q < 6'(need) || n_q >= etd_pkg::MAX_RESULTS) begin
              brk = 1'b1;
            end else begin
              run_new  = 1'b1;
              run.word = tile;
              held_d   = held_q - 6'(need);
              pend_d   = pend_q - 5'd1;
            end
          end else if (held_q == 6'd0 || n_q > etd_pkg::CMD_ROOM) begin
            brk = 1'b1;
          end else if (!aligned[31]) begin
            // short command: incrementing or static run
            if (held_q < 6'(etd_pkg::CMD_SHORT_BITS)) begin
              brk = 1'b1;
            end else begin
              run_new   = 1'b1;
              run.count = cnt6;
              held_d    = held_q - 6'(etd_pkg::CMD_SHORT_BITS);
              if (aligned[30]) begin
                run.word = static_tile_q;
              end else begin
                run.word  = up_tile_q;
                run.step  = etd_pkg::STEP_UP;
                up_tile_d = up_tile_q + 16'(cnt6) + 16'd1;
              end
            end
          end else if (held_q < 6'(etd_pkg::CMD_LONG_BITS)) begin
            brk = 1'b1;
          end else if (mode == etd_pkg::MODE_INLINE) begin
            held_d = held_q - 6'(etd_pkg::CMD_LONG_BITS);
            if (cnt7 == etd_pkg::COUNT_END) begin
              // end of stream: drop held bits, back to header
              run_new        = 1'b1;
              run.stream_end = 1'b1;
              hdr_phase_d    = '0;
              held_d         = '0;
              acc_d          = '0;
              pend_d         = '0;
            end else begin
              pend_d = 5'(cnt7) + 5'd1;
            end
          end else if (held_q < need_cmd) begin
            brk = 1'b1;
          end else begin
            // decoded tile run
            run_new   = 1'b1;
            run.word  = tile;
            run.count = cnt7;
            held_d    = held_q - need_cmd;
            case (mode)
              etd_pkg::MODE_INC: run.step = etd_pkg::STEP_UP;
              etd_pkg::MODE_DEC: run.step = etd_pkg::STEP_DOWN;
              default:           run.step = etd_pkg::STEP_HOLD;
            endcase
          end

          // held run goes out once its successor or the byte end is known
          if ((run_new || brk) && hold_valid_q) begin
            push_o           = 1'b1;
            push_data_o.last = brk;
          end
          if (run_new) begin
            hold_d       = run;
            hold_valid_d = 1'b1;
            n_d          = n_q + 6'(run.count) + 6'd1;
          end
          if (brk) begin
            hold_valid_d = 1'b0;
            state_d      = F_IDLE;
          end
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // state and decoder registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= F_IDLE;
      hdr_phase_q   <= '0;
      tile_bits_q   <= '0;
      vflip_q       <= 1'b0;
      hflip_q       <= 1'b0;
      hi_byte_q     <= '0;
      up_tile_q     <= '0;
      static_tile_q <= '0;
      acc_q         <= '0;
      held_q        <= '0;
      pend_q        <= '0;
      n_q           <= '0;
      hold_valid_q  <= 1'b0;
      hold_q        <= '0;
    end else begin
      state_q       <= state_d;
      hdr_phase_q   <= hdr_phase_d;
      tile_bits_q   <= tile_bits_d;
      vflip_q       <= vflip_d;
      hflip_q       <= hflip_d;
      hi_byte_q     <= hi_byte_d;
      up_tile_q     <= up_tile_d;
      static_tile_q <= static_tile_d;
      acc_q         <= acc_d;
      held_q        <= held_d;
      pend_q        <= pend_d;
      n_q           <= n_d;
      hold_valid_q  <= hold_valid_d;
      hold_q        <= hold_d;
    end
  end

  // no run is left behind when a new byte may enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_IDLE |-> !hold_valid_q)
    else $error("run held while idle");

  // the bit reader never holds more than its accumulator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= 6'd32)
    else $error("bit reader overflow");

  // words per byte stay within bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= etd_pkg::MAX_RESULTS)
    else $error("too many words for one byte");

endmodule

// File: sv/etd_fifo.sv
// short run queue between command decoder and word expander
// depends on etd_pkg for the run entry type
module etd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  etd_pkg::run_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output etd_pkg::run_t pop_data_o,
  output logic          empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  etd_pkg::run_t   mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full run queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty run queue");

endmodule

// File: sv/etd_back.sv
// back end: expands queued runs into tilemap words behind an output register
// depends on etd_pkg for the run entry type
module etd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  etd_pkg::run_t pop_data_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [15:0]   tile_word_o,
  output logic          stream_end_o,
  output logic          last_o
);

  logic                busy_q;
  logic [15:0]         word_q;
  logic [3:0]          rem_q;
  etd_pkg::run_step_e  step_q;
  logic                end_q;
  logic                run_last_q;
  logic                out_valid_q;
  logic [15:0]         out_word_q;
  logic                out_end_q;
  logic                out_last_q;
  logic                slot_free;
  logic [15:0]         word_next;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = !busy_q && !empty_i;

  // next word of the current run
  always_comb begin
    case (step_q)
      etd_pkg::STEP_UP:   word_next = word_q + 16'd1;
      etd_pkg::STEP_DOWN: word_next = word_q - 16'd1;
      default:            word_next = word_q;
    endcase
  end

  // run expansion and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      word_q      <= '0;
      rem_q       <= '0;
      step_q      <= etd_pkg::STEP_HOLD;
      end_q       <= 1'b0;
      run_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_end_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q     <= 1'b1;
        word_q     <= pop_data_i.word;
        rem_q      <= pop_data_i.count;
        step_q     <= pop_data_i.step;
        end_q      <= pop_data_i.stream_end;
        run_last_q <= pop_data_i.last;
      end
      if (slot_free) begin
        out_valid_q <= busy_q;
        if (busy_q) begin
          out_word_q <= word_q;
          out_end_q  <= end_q;
          out_last_q <= run_last_q && (rem_q == 4'd0);
          word_q     <= word_next;
          rem_q      <= rem_q - 4'd1;
          if (rem_q == 4'd0) begin
            busy_q <= 1'b0;
          end
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tile_word_o  = out_word_q;
  assign stream_end_o = out_end_q;
  assign last_o       = out_last_q;

  // the end word closes its byte and carries no tile
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_end_o |-> last_o && tile_word_o == 16'd0)
    else $error("malformed end word");

  // a new run is only taken once the previous one is spent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !busy_q)
    else $error("run overwritten");

endmodule

// File: sv/enigma_tilemap_decompressor.sv
// top level of the enigma tilemap decompressor: base tile register,
// command decoder, run queue and word expander; depends on etd_pkg
//
//   channel  direction  signals                                  taken when
//   cfg      in         cfg_we_i, cfg_wdata_i                    cfg_we_i
//   byte     in         in_valid_i/in_ready_o, data_byte_i       valid && ready
//   word     out        out_valid_o/out_ready_i, tile_word_o,    valid && ready
//                       stream_end_o, last_o
//
// each header byte is taken while the decoder is idle; a stream byte is loaded into the bit
// reader, then the decoder steps through each command, inline tile or end code in turn
// and ends with a step that closes the byte.
// the expander loads each run into its run registers, then gives one word per cycle.
// asynchronous active-low reset clears all control state; no clearing pass.
// the decoder stalls while the run queue is full and a run is held; the expander on out_ready_i.
module enigma_tilemap_decompressor #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] tile_word_o,
  output logic        stream_end_o,
  output logic        last_o
);

  logic [15:0]   tile_base_q;
  logic          push, full, pop, empty;
  etd_pkg::run_t push_data, pop_data;

  // base tile register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_base_q <= '0;
    end else if (cfg_we_i) begin
      tile_base_q <= cfg_wdata_i;
    end
  end

  // command decoder
  etd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tile_base_i (tile_base_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // run queue
  etd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // word expander
  etd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_data_i   (pop_data),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .tile_word_o  (tile_word_o),
    .stream_end_o (stream_end_o),
    .last_o       (last_o)
  );

endmodule
